/* design/stk_pkg.sv */
package stk_pkg;

   // Command codes carried in the request beat.
   localparam logic [1:0] CMD_PUSH = 2'd0;
   localparam logic [1:0] CMD_POP  = 2'd1;
   localparam logic [1:0] CMD_XMAX = 2'd2;

   // Status codes carried in the response beat.
   localparam logic [1:0] STS_OK    = 2'd0;
   localparam logic [1:0] STS_EMPTY = 2'd1;
   localparam logic [1:0] STS_FULL  = 2'd2;

   localparam int DATA_W  = 32;
   localparam int COUNT_W = 7;

   typedef struct packed {
      logic [1:0]               command;
      logic signed [DATA_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic [1:0]               status;
      logic [COUNT_W-1:0]       entry_count;
   } rsp_type;

endpackage

/* design/stk_ram.sv */
module stk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/stack_with_extract_max_top.sv */
// Push, a full push, an empty pop or extract, and the unused code: one beat per cycle while
// the output has room. Pop: the RAM read, then the response load, before the next beat.
// Extract-max runs two sweeps over the single RAM read port
// (one pass finds the maximum, a second pass compacts the survivors in place).
// Synchronous active-high reset empties the stack and drops any pending response;
// the entry RAM is not cleared, since only entries below the fill count are ever read.
module stack_with_extract_max_top #(
   parameter int DEPTH = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  stk_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output stk_pkg::rsp_type rsp_payload
);

   import stk_pkg::*;

   // Address width indexes the entry RAM; count width must also hold DEPTH itself.
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_POP_RD = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_PURGE  = 5'b01000,
      ST_RESP   = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // Stack pointer: number of valid entries, entries live at addresses 0..count-1.
   logic [CW-1:0] fill_count_ff, fill_count_in;

   // Sweep control shared by both extract passes. rd_idx is the next address to
   // read; rd_vld marks that the RAM output holds data from the previous cycle.
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [CW-1:0] wr_idx_ff, wr_idx_in;
   logic          first_ff, first_in;
   logic signed [DATA_W-1:0] best_ff, best_in;

   // A finished result parks in pend until the output register can take it.
   rsp_type pend_ff, pend_in;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [DATA_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [DATA_W-1:0] ram_rd_data;

   logic                     accept;
   logic                     out_free;
   logic                     issue;
   logic signed [DATA_W-1:0] rd_sgn;
   logic signed [DATA_W-1:0] best_upd;
   logic                     keep;

   stk_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Requests are taken whenever the sequencer is idle, even while an older
   // response beat still waits in the output register.
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Both sweeps read one entry per cycle while addresses remain.
   assign issue    = (rd_idx_ff < fill_count_ff);
   assign rd_sgn   = signed'(ram_rd_data);
   assign best_upd = (first_ff || (rd_sgn > best_ff)) ? rd_sgn : best_ff;
   assign keep     = (rd_sgn != best_ff);

   always_comb begin
      logic    imm;
      rsp_type imm_rsp;
      logic [CW-1:0] new_count;

      imm       = 1'b0;
      imm_rsp   = '0;
      new_count = '0;

      state_in      = state_ff;
      fill_count_in = fill_count_ff;
      rd_idx_in     = rd_idx_ff;
      rd_vld_in     = 1'b0;
      wr_idx_in     = wr_idx_ff;
      first_in      = first_ff;
      best_in       = best_ff;
      pend_in       = pend_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      ram_wr_en   = 1'b0;
      ram_wr_addr = fill_count_ff[AW-1:0];
      ram_wr_data = req_payload.push_value;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_payload.command)
                  CMD_PUSH: begin
                     imm = 1'b1;
                     if (fill_count_ff == DEPTH_C) begin
                        imm_rsp = '{result_value: '0, status: STS_FULL,
                                    entry_count: COUNT_W'(fill_count_ff)};
                     end else begin
                        ram_wr_en     = 1'b1;
                        fill_count_in = fill_count_ff + ONE_C;
                        imm_rsp = '{result_value: '0, status: STS_OK,
                                    entry_count: COUNT_W'(fill_count_ff + ONE_C)};
                     end
                  end
                  CMD_POP: begin
                     if (fill_count_ff == '0) begin
                        imm     = 1'b1;
                        imm_rsp = '{result_value: '0, status: STS_EMPTY, entry_count: '0};
                     end else begin
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = AW'(fill_count_ff - ONE_C);
                        fill_count_in = fill_count_ff - ONE_C;
                        state_in      = ST_POP_RD;
                     end
                  end
                  CMD_XMAX: begin
                     if (fill_count_ff == '0) begin
                        imm     = 1'b1;
                        imm_rsp = '{result_value: '0, status: STS_EMPTY, entry_count: '0};
                     end else begin
                        // Start the maximum search at the bottom of the stack.
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        rd_idx_in   = ONE_C;
                        rd_vld_in   = 1'b1;
                        first_in    = 1'b1;
                        state_in    = ST_SCAN;
                     end
                  end
                  default: begin
                     // The unused command code leaves the stack alone.
                     imm     = 1'b1;
                     imm_rsp = '{result_value: '0, status: STS_OK,
                                 entry_count: COUNT_W'(fill_count_ff)};
                  end
               endcase
               // Immediate commands go straight to the output when it has room.
               if (imm) begin
                  if (out_free) begin
                     rsp_in       = imm_rsp;
                     rsp_valid_in = 1'b1;
                  end else begin
                     pend_in  = imm_rsp;
                     state_in = ST_RESP;
                  end
               end
            end
         end
         ST_POP_RD: begin
            pend_in  = '{result_value: rd_sgn, status: STS_OK,
                         entry_count: COUNT_W'(fill_count_ff)};
            state_in = ST_RESP;
         end
         ST_SCAN: begin
            if (issue) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = rd_idx_ff[AW-1:0];
               rd_idx_in   = rd_idx_ff + ONE_C;
               rd_vld_in   = 1'b1;
            end
            if (rd_vld_ff) begin
               best_in  = best_upd;
               first_in = 1'b0;
            end
            // Last entry has arrived: begin the compaction pass from the bottom.
            if (rd_vld_ff && !issue) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = '0;
               rd_idx_in   = ONE_C;
               rd_vld_in   = 1'b1;
               wr_idx_in   = '0;
               state_in    = ST_PURGE;
            end
         end
         ST_PURGE: begin
            if (issue) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = rd_idx_ff[AW-1:0];
               rd_idx_in   = rd_idx_ff + ONE_C;
               rd_vld_in   = 1'b1;
            end
            // Survivors slide down; the write pointer never passes the read pointer.
            if (rd_vld_ff && keep) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = wr_idx_ff[AW-1:0];
               ram_wr_data = ram_rd_data;
               wr_idx_in   = wr_idx_ff + ONE_C;
            end
            if (rd_vld_ff && !issue) begin
               new_count     = wr_idx_ff + (keep ? ONE_C : '0);
               fill_count_in = new_count;
               pend_in       = '{result_value: best_ff, status: STS_OK,
                                 entry_count: COUNT_W'(new_count)};
               state_in      = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_count_ff <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_count_ff <= fill_count_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      wr_idx_ff <= wr_idx_in;
      first_ff  <= first_in;
      best_ff   <= best_in;
      pend_ff   <= pend_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= DEPTH_C)
      else $error("fill count exceeds stack depth");

   a_wr_behind_rd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PURGE) && ram_wr_en |-> wr_idx_ff < rd_idx_ff)
      else $error("compaction write overtook the read pointer");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      accept && (req_payload.command == CMD_PUSH) && (fill_count_ff != DEPTH_C)
      |=> fill_count_ff == $past(fill_count_ff) + ONE_C)
      else $error("push did not grow the stack by one");

   a_purge_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PURGE) && (state_in == ST_RESP) |-> fill_count_in < fill_count_ff)
      else $error("extract did not remove the maximum");

endmodule
